// ===== rtl/mwm_pkg.sv =====
`default_nettype none

package mwm_pkg;

  localparam int FRACTION_BITS = 14;

  localparam int AXIS_W      = 16;
  localparam int TERM_W      = 17;
  localparam int WHEEL_W     = 18;
  localparam int WMAG_W      = 17;
  localparam int CMD_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int LEVEL_W     = 15;
  localparam int CFG_W       = 16;
  localparam int REG_IDX_W   = 2;
  localparam int NUM_WHEELS  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REG_IDX_W-1:0] REG_DEADBAND    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_GAIN  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIVOT_SPEED = 2'd2;

  localparam logic [LEVEL_W-1:0] DEADBAND_RESET    = 15'd1638;
  localparam logic [GAIN_W-1:0]  RIGHT_GAIN_RESET  = 16'd64250;
  localparam logic [LEVEL_W-1:0] PIVOT_SPEED_RESET = 15'd11469;

  typedef enum logic [1:0] {
    MODE_MIX,
    MODE_PIVOT_NEG,
    MODE_PIVOT_POS
  } mode_t;

  typedef logic signed [WHEEL_W-1:0] wheel_t;

  typedef struct packed {
    mode_t                       mode;
    logic                        zero_enc;
    wheel_t [NUM_WHEELS-1:0]     wheel;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] deadband_level;
    logic [GAIN_W-1:0]  right_side_gain;
    logic [LEVEL_W-1:0] pivot_speed;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/mecanum_wheel_mixer_core.sv =====
// Mecanum wheel mixer: one control tick of stick axes and buttons in, four
// wheel motor commands (Q1.14) and an encoder-zero flag out.
// Input channel: in_valid / in_stall; an item transfers on a rising edge with
// in_valid high and in_stall low. Result channel: out_valid / out_stall, same
// rule. Exactly one result per input item, in order.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 deadband_level, 1 right_side_gain, 2 pivot_speed); write only when idle.
// A front stage registers the deadbanded drive terms and the half-speed state,
// then hands wheel sums to a two-entry queue. The back end scans for the peak
// magnitude, then per wheel runs a shared restoring divider (only when the
// peak exceeds one in mix mode) and, for the right-side wheels, the trim
// multiplier.
// The back end works on one item at a time; the front stage and the queue
// take further items while it is busy.
// Reset: synchronous, active low; half mode off, queue empty, registers at
// their defaults. When out_stall holds, the result stays put, the back end
// finishes one more item, and the queue fills before in_stall rises.
`default_nettype none

module mecanum_wheel_mixer_core #(
  parameter int FRACTION_BITS = mwm_pkg::FRACTION_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mwm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire logic [mwm_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]   in_stick_forward,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]   in_stick_sideways,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]   in_throttle_axis,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]   in_twist_axis,
  input  wire logic                                in_half_speed_button,
  input  wire logic                                in_zero_encoders_button,
  input  wire logic                                in_pivot_left_button,
  input  wire logic                                in_pivot_right_button,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [mwm_pkg::CMD_W-1:0]         out_front_left_cmd,
  output logic signed [mwm_pkg::CMD_W-1:0]         out_front_right_cmd,
  output logic signed [mwm_pkg::CMD_W-1:0]         out_back_left_cmd,
  output logic signed [mwm_pkg::CMD_W-1:0]         out_back_right_cmd,
  output logic                                     out_zero_encoders
);

  mwm_pkg::cfg_t  cfg_r;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  mwm_pkg::item_t push_data;
  mwm_pkg::item_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_level  <= mwm_pkg::DEADBAND_RESET;
      cfg_r.right_side_gain <= mwm_pkg::RIGHT_GAIN_RESET;
      cfg_r.pivot_speed     <= mwm_pkg::PIVOT_SPEED_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mwm_pkg::REG_DEADBAND:    cfg_r.deadband_level  <= cfg_data[mwm_pkg::LEVEL_W-1:0];
        mwm_pkg::REG_RIGHT_GAIN:  cfg_r.right_side_gain <= cfg_data[mwm_pkg::GAIN_W-1:0];
        mwm_pkg::REG_PIVOT_SPEED: cfg_r.pivot_speed     <= cfg_data[mwm_pkg::LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mwm_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .deadband_i             (cfg_r.deadband_level),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .stick_forward_i        (in_stick_forward),
    .stick_sideways_i       (in_stick_sideways),
    .throttle_axis_i        (in_throttle_axis),
    .twist_axis_i           (in_twist_axis),
    .half_speed_button_i    (in_half_speed_button),
    .zero_encoders_button_i (in_zero_encoders_button),
    .pivot_left_button_i    (in_pivot_left_button),
    .pivot_right_button_i   (in_pivot_right_button),
    .push_o                 (push),
    .push_data_o            (push_data),
    .full_i                 (full)
  );

  mwm_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  mwm_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_i             (cfg_r),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .front_left_cmd_o  (out_front_left_cmd),
    .front_right_cmd_o (out_front_right_cmd),
    .back_left_cmd_o   (out_back_left_cmd),
    .back_right_cmd_o  (out_back_right_cmd),
    .zero_encoders_o   (out_zero_encoders)
  );

endmodule

`default_nettype wire

// ===== rtl/mwm_front.sv =====
`default_nettype none

module mwm_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [mwm_pkg::LEVEL_W-1:0]          deadband_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]    stick_forward_i,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]    stick_sideways_i,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]    throttle_axis_i,
  input  wire logic signed [mwm_pkg::AXIS_W-1:0]    twist_axis_i,
  input  wire logic                                 half_speed_button_i,
  input  wire logic                                 zero_encoders_button_i,
  input  wire logic                                 pivot_left_button_i,
  input  wire logic                                 pivot_right_button_i,
  output logic                                      push_o,
  output mwm_pkg::item_t                            push_data_o,
  input  wire logic                                 full_i
);

  localparam int TW = mwm_pkg::TERM_W;
  localparam int WW = mwm_pkg::WHEEL_W;

  function automatic logic signed [TW-1:0] halve_term(input logic signed [TW-1:0] v,
                                                     input logic half);
    logic signed [TW-1:0] adj;
    adj = v + $signed({{(TW-1){1'b0}}, v[TW-1]});
    return half ? (adj >>> 1) : v;
  endfunction

  function automatic logic signed [TW-1:0] dead_term(input logic signed [TW-1:0] v,
                                                    input logic [mwm_pkg::LEVEL_W-1:0] lvl);
    logic [TW-1:0] m;
    m = v[TW-1] ? TW'(-v) : TW'(v);
    return (m < TW'(lvl)) ? '0 : v;
  endfunction

  logic                  s1_valid_r;
  logic                  half_mode_r;
  logic                  last_half_r;
  logic signed [TW-1:0]  y_r, x_r, r_r;
  mwm_pkg::mode_t        mode_r;
  logic                  zero_r;

  logic                  accept;
  logic                  half_now;
  logic signed [TW-1:0]  fwd_t, side_t, rot_t;
  logic signed [WW-1:0]  y_w, x_w, r_w;
  mwm_pkg::mode_t        mode_in;

  assign in_stall_o = s1_valid_r & full_i;
  assign push_o     = s1_valid_r & ~full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign half_now   = half_mode_r ^ (half_speed_button_i & ~last_half_r);

  assign fwd_t  = TW'(stick_forward_i);
  assign side_t = -TW'(stick_sideways_i);
  assign rot_t  = TW'(twist_axis_i) - TW'(throttle_axis_i);

  always_comb begin
    if (pivot_left_button_i) begin
      mode_in = mwm_pkg::MODE_PIVOT_NEG;
    end else if (pivot_right_button_i) begin
      mode_in = mwm_pkg::MODE_PIVOT_POS;
    end else begin
      mode_in = mwm_pkg::MODE_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      half_mode_r <= 1'b0;
      last_half_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r  <= 1'b1;
        half_mode_r <= half_now;
        last_half_r <= half_speed_button_i;
      end else if (push_o) begin
        s1_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      y_r    <= dead_term(halve_term(fwd_t, half_now), deadband_i);
      x_r    <= dead_term(halve_term(side_t, half_now), deadband_i);
      r_r    <= dead_term(halve_term(rot_t, half_now), deadband_i);
      mode_r <= mode_in;
      zero_r <= zero_encoders_button_i;
    end
  end

  assign y_w = WW'(y_r);
  assign x_w = WW'(x_r);
  assign r_w = WW'(r_r);

  always_comb begin
    push_data_o.mode     = mode_r;
    push_data_o.zero_enc = zero_r;
    push_data_o.wheel[0] = x_w + y_w + r_w;
    push_data_o.wheel[1] = -x_w + y_w - r_w;
    push_data_o.wheel[2] = -x_w + y_w + r_w;
    push_data_o.wheel[3] = x_w + y_w - r_w;
  end

`ifndef SYNTHESIS
  a_half_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && half_speed_button_i && !last_half_r) |=> (half_mode_r != $past(half_mode_r)))
    else $error("half mode did not toggle on button rising edge");
`endif

endmodule

`default_nettype wire

// ===== rtl/mwm_queue.sv =====
`default_nettype none

module mwm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire mwm_pkg::item_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output mwm_pkg::item_t      head_o
);

  localparam int DEPTH = mwm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mwm_pkg::item_t      mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/mwm_back.sv =====
`default_nettype none

module mwm_back #(
  parameter int FRACTION_BITS = mwm_pkg::FRACTION_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mwm_pkg::cfg_t                       cfg_i,
  input  wire logic                                empty_i,
  input  wire mwm_pkg::item_t                      head_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [mwm_pkg::CMD_W-1:0]         front_left_cmd_o,
  output logic signed [mwm_pkg::CMD_W-1:0]         front_right_cmd_o,
  output logic signed [mwm_pkg::CMD_W-1:0]         back_left_cmd_o,
  output logic signed [mwm_pkg::CMD_W-1:0]         back_right_cmd_o,
  output logic                                     zero_encoders_o
);

  localparam int WW     = mwm_pkg::WHEEL_W;
  localparam int MW     = mwm_pkg::WMAG_W;
  localparam int CW     = mwm_pkg::CMD_W;
  localparam int GW     = mwm_pkg::GAIN_W;
  localparam int NW     = mwm_pkg::NUM_WHEELS;
  localparam int QW     = FRACTION_BITS + 1;
  localparam int MAG_W  = (QW > MW) ? QW : MW;
  localparam int CMP_W  = MAG_W + 1;
  localparam int PROD_W = MAG_W + GW;
  localparam int CNT_W  = $clog2(FRACTION_BITS + 1);
  localparam int IDX_W  = $clog2(NW);

  localparam logic [CMP_W-1:0] ONE_EXT   = CMP_W'(1) << FRACTION_BITS;
  localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'((1 << (CW - 1)) - 1);
  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(1 << (CW - 1));
  localparam logic [CW-1:0]    CMD_MAX   = CW'((1 << (CW - 1)) - 1);
  localparam logic [CW-1:0]    CMD_MIN   = CW'(1 << (CW - 1));
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_MUL,
    S_WRITE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  mwm_pkg::item_t      ent_r, ent_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [MW-1:0]       mx_r, mx_nxt;
  logic                norm_r, norm_nxt;
  logic                neg_r, neg_nxt;
  logic [MW-1:0]       rem_r, rem_nxt;
  logic                mbit_r, mbit_nxt;
  logic [QW-1:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic [MAG_W-1:0]    res_r, res_nxt;
  logic [CW-1:0]       cmd_r [NW];
  logic [CW-1:0]       cmd_nxt [NW];
  logic [CW-1:0]       out_cmd_r [NW];
  logic [CW-1:0]       out_cmd_nxt [NW];
  logic                out_zero_r, out_zero_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic signed [WW-1:0] wheel_sel;
  logic                 w_neg;
  logic [MW-1:0]        w_mag;
  logic [MW-1:0]        mx_cand;
  logic                 div_bit;
  logic [MW:0]          trial;
  logic [MW:0]          diff;
  logic                 fits;
  logic [QW-1:0]        quo_shift;
  logic [PROD_W-1:0]    product;
  logic [MAG_W-1:0]     neg_mag;
  logic [CW-1:0]        sat_cmd;

  assign wheel_sel = $signed(ent_r.wheel[idx_r]);
  assign w_neg     = wheel_sel[WW-1];
  assign w_mag     = w_neg ? MW'(-wheel_sel) : MW'(wheel_sel);
  assign mx_cand   = (w_mag > mx_r) ? w_mag : mx_r;

  assign div_bit   = (cnt_r == CNT_W'(FRACTION_BITS)) ? mbit_r : 1'b0;
  assign trial     = {rem_r, div_bit};
  assign fits      = (trial >= {1'b0, mx_r});
  assign diff      = trial - {1'b0, mx_r};
  assign quo_shift = {quo_r[QW-2:0], fits};

  assign product   = mag_r * cfg_i.right_side_gain;

  assign neg_mag   = MAG_W'(0) - res_r;

  always_comb begin
    if (neg_r) begin
      sat_cmd = (res_r > NEG_LIMIT) ? CMD_MIN : neg_mag[CW-1:0];
    end else begin
      sat_cmd = (res_r > POS_LIMIT) ? CMD_MAX : res_r[CW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    idx_nxt       = idx_r;
    mx_nxt        = mx_r;
    norm_nxt      = norm_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    mbit_nxt      = mbit_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    mag_nxt       = mag_r;
    res_nxt       = res_r;
    cmd_nxt       = cmd_r;
    out_cmd_nxt   = out_cmd_r;
    out_zero_nxt  = out_zero_r;
    out_valid_nxt = out_valid_r;
    pop_o         = 1'b0;

    if (out_valid_r && !out_stall_i) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o     = 1'b1;
          ent_nxt   = head_i;
          idx_nxt   = '0;
          mx_nxt    = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        mx_nxt = mx_cand;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          norm_nxt  = (ent_r.mode == mwm_pkg::MODE_MIX) && (CMP_W'(mx_cand) > ONE_EXT);
          state_nxt = S_PREP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_PREP: begin
        case (ent_r.mode)
          mwm_pkg::MODE_MIX: begin
            neg_nxt = idx_r[0] ? w_neg : ~w_neg;
            if (norm_r) begin
              rem_nxt   = w_mag >> 1;
              mbit_nxt  = w_mag[0];
              quo_nxt   = '0;
              cnt_nxt   = CNT_W'(FRACTION_BITS);
              state_nxt = S_DIV;
            end else begin
              mag_nxt   = MAG_W'(w_mag);
              state_nxt = S_MUL;
            end
          end
          mwm_pkg::MODE_PIVOT_NEG, mwm_pkg::MODE_PIVOT_POS: begin
            neg_nxt   = (ent_r.mode == mwm_pkg::MODE_PIVOT_NEG) && idx_r[1];
            mag_nxt   = idx_r[1] ? MAG_W'(cfg_i.pivot_speed) : '0;
            state_nxt = S_MUL;
          end
          default: begin
            neg_nxt   = 1'b0;
            mag_nxt   = '0;
            state_nxt = S_MUL;
          end
        endcase
      end
      S_DIV: begin
        rem_nxt = fits ? diff[MW-1:0] : trial[MW-1:0];
        quo_nxt = quo_shift;
        if (cnt_r == '0) begin
          mag_nxt   = MAG_W'(quo_shift);
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MUL: begin
        res_nxt   = idx_r[0] ? product[PROD_W-1:GW] : mag_r;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd_nxt[idx_r] = sat_cmd;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall_i) begin
          out_cmd_nxt   = cmd_r;
          out_zero_nxt  = ent_r.zero_enc;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ent_r      <= ent_nxt;
    idx_r      <= idx_nxt;
    mx_r       <= mx_nxt;
    norm_r     <= norm_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    mbit_r     <= mbit_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    mag_r      <= mag_nxt;
    res_r      <= res_nxt;
    cmd_r      <= cmd_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_valid_o       = out_valid_r;
  assign front_left_cmd_o  = $signed(out_cmd_r[0]);
  assign front_right_cmd_o = $signed(out_cmd_r[1]);
  assign back_left_cmd_o   = $signed(out_cmd_r[2]);
  assign back_right_cmd_o  = $signed(out_cmd_r[3]);
  assign zero_encoders_o   = out_zero_r;

`ifndef SYNTHESIS
  a_div_only_when_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (norm_r && ent_r.mode == mwm_pkg::MODE_MIX))
    else $error("divider running without normalization");
  a_wheel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && ent_r.mode == mwm_pkg::MODE_MIX) |-> (CMP_W'(mag_r) <= ONE_EXT))
    else $error("normalized wheel magnitude exceeds one");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result presented outside completion");
`endif

endmodule

`default_nettype wire

// ===== tb/mecanum_wheel_mixer_core_test.sv =====
`default_nettype none

module mecanum_wheel_mixer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mwm_pkg::*;

  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     NUM_PHASES      = 6;
  localparam int     SETTLE_CYCLES   = 100;
  localparam longint CYCLE_LIMIT     = 1000000;

  typedef struct {
    logic signed [AXIS_W-1:0] fwd;
    logic signed [AXIS_W-1:0] side;
    logic signed [AXIS_W-1:0] thr;
    logic signed [AXIS_W-1:0] tw;
    logic                     hb;
    logic                     zb;
    logic                     pl;
    logic                     pr;
  } tick_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] fl;
    logic signed [CMD_W-1:0] fr;
    logic signed [CMD_W-1:0] bl;
    logic signed [CMD_W-1:0] br;
    logic                    zero;
  } cmds_t;

  typedef struct {
    tick_t tick;
    bit    known;
    cmds_t cmds;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [AXIS_W-1:0] in_stick_forward;
  logic signed [AXIS_W-1:0] in_stick_sideways;
  logic signed [AXIS_W-1:0] in_throttle_axis;
  logic signed [AXIS_W-1:0] in_twist_axis;
  logic in_half_speed_button;
  logic in_zero_encoders_button;
  logic in_pivot_left_button;
  logic in_pivot_right_button;
  logic out_valid;
  logic out_stall;
  logic signed [CMD_W-1:0] out_front_left_cmd;
  logic signed [CMD_W-1:0] out_front_right_cmd;
  logic signed [CMD_W-1:0] out_back_left_cmd;
  logic signed [CMD_W-1:0] out_back_right_cmd;
  logic out_zero_encoders;

  logic half_mode_q;
  logic last_half_q;
  logic [LEVEL_W-1:0] deadband_q;
  logic [GAIN_W-1:0] gain_q;
  logic [LEVEL_W-1:0] pivot_q;

  cmds_t expected_cmds[$];
  plan_row_t directed_plan[$];
  int mismatch_cnt = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  longint cycle_cnt = 0;

  mecanum_wheel_mixer_core uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_stick_forward        (in_stick_forward),
    .in_stick_sideways       (in_stick_sideways),
    .in_throttle_axis        (in_throttle_axis),
    .in_twist_axis           (in_twist_axis),
    .in_half_speed_button    (in_half_speed_button),
    .in_zero_encoders_button (in_zero_encoders_button),
    .in_pivot_left_button    (in_pivot_left_button),
    .in_pivot_right_button   (in_pivot_right_button),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_front_left_cmd      (out_front_left_cmd),
    .out_front_right_cmd     (out_front_right_cmd),
    .out_back_left_cmd       (out_back_left_cmd),
    .out_back_right_cmd      (out_back_right_cmd),
    .out_zero_encoders       (out_zero_encoders)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint shape_term(input longint v);
    longint h;
    h = half_mode_q ? v / 2 : v;
    return (magnitude(h) < longint'(deadband_q)) ? 0 : h;
  endfunction

  function automatic longint trim_right(input longint v);
    return (v * longint'(gain_q)) / 65536;
  endfunction

  function automatic logic signed [CMD_W-1:0] saturate_cmd(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CMD_W-1:0];
  endfunction

  // one control tick: update half mode, mix, normalize, trim, override
  function automatic cmds_t mix_tick(input tick_t t);
    longint one, drive, strafe, turn, peak;
    longint w[4];
    cmds_t c;
    one = longint'(1) << FRACTION_BITS;
    if (t.hb && !last_half_q) half_mode_q = !half_mode_q;
    last_half_q = t.hb;
    drive = shape_term(longint'(t.fwd));
    strafe = shape_term(-longint'(t.side));
    turn = shape_term(longint'(t.tw) - longint'(t.thr));
    w[0] = strafe + drive + turn;
    w[1] = -strafe + drive - turn;
    w[2] = -strafe + drive + turn;
    w[3] = strafe + drive - turn;
    peak = 0;
    for (int i = 0; i < 4; i++)
      if (magnitude(w[i]) > peak) peak = magnitude(w[i]);
    if (peak > one)
      for (int i = 0; i < 4; i++)
        w[i] = (w[i] * one) / peak;
    if (t.pl) begin
      c.fl = '0;
      c.fr = '0;
      c.bl = saturate_cmd(-longint'(pivot_q));
      c.br = saturate_cmd(trim_right(-longint'(pivot_q)));
    end else if (t.pr) begin
      c.fl = '0;
      c.fr = '0;
      c.bl = saturate_cmd(longint'(pivot_q));
      c.br = saturate_cmd(trim_right(longint'(pivot_q)));
    end else begin
      c.fl = saturate_cmd(-w[0]);
      c.fr = saturate_cmd(trim_right(w[1]));
      c.bl = saturate_cmd(-w[2]);
      c.br = saturate_cmd(trim_right(w[3]));
    end
    c.zero = t.zb;
    return c;
  endfunction

  function automatic int pick_idle();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [AXIS_W-1:0] random_axis();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = -16384;
          2: v = 16384;
          3: v = 32767;
          default: v = 0;
        endcase
      end
      2: begin
        v = int'(deadband_q) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return AXIS_W'(v);
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    t.fwd = random_axis();
    t.side = random_axis();
    t.thr = random_axis();
    t.tw = random_axis();
    t.hb = ($urandom_range(0, 2) == 0);
    t.zb = ($urandom_range(0, 1) == 1);
    t.pl = ($urandom_range(0, 9) == 0);
    t.pr = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  task automatic add_row(input int fwd, input int side, input int thr, input int tw,
                         input logic [3:0] btn, input bit known,
                         input int fl, input int fr, input int bl, input int br);
    plan_row_t row;
    row.tick.fwd = AXIS_W'(fwd);
    row.tick.side = AXIS_W'(side);
    row.tick.thr = AXIS_W'(thr);
    row.tick.tw = AXIS_W'(tw);
    {row.tick.hb, row.tick.zb, row.tick.pl, row.tick.pr} = btn;
    row.known = known;
    row.cmds.fl = CMD_W'(fl);
    row.cmds.fr = CMD_W'(fr);
    row.cmds.bl = CMD_W'(bl);
    row.cmds.br = CMD_W'(br);
    row.cmds.zero = btn[2];
    directed_plan.push_back(row);
  endtask

  task automatic send_tick(input tick_t t, input bit known, input cmds_t typed);
    int gap;
    cmds_t predicted;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stick_forward <= t.fwd;
    in_stick_sideways <= t.side;
    in_throttle_axis <= t.thr;
    in_twist_axis <= t.tw;
    in_half_speed_button <= t.hb;
    in_zero_encoders_button <= t.zb;
    in_pivot_left_button <= t.pl;
    in_pivot_right_button <= t.pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = mix_tick(t);
    expected_cmds.push_back(known ? typed : predicted);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [LEVEL_W-1:0] level, input logic [GAIN_W-1:0] gain,
                              input logic [LEVEL_W-1:0] pivot);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DEADBAND;
    cfg_data <= CFG_W'(level);
    deadband_q = level;
    @(posedge clk);
    cfg_index <= REG_RIGHT_GAIN;
    cfg_data <= gain;
    gain_q = gain;
    @(posedge clk);
    cfg_index <= REG_PIVOT_SPEED;
    cfg_data <= CFG_W'(pivot);
    pivot_q = pivot;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else stall_left = pick_idle();
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin : check_result
    cmds_t got;
    cmds_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.fl = out_front_left_cmd;
      got.fr = out_front_right_cmd;
      got.bl = out_back_left_cmd;
      got.br = out_back_right_cmd;
      got.zero = out_zero_encoders;
      if (expected_cmds.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] transfer out with nothing pending: fl=%0d fr=%0d bl=%0d br=%0d z=%0d",
                   $realtime, got.fl, got.fr, got.bl, got.br, got.zero);
      end else begin
        want = expected_cmds.pop_front();
        if (got.fl !== want.fl || got.fr !== want.fr || got.bl !== want.bl ||
            got.br !== want.br || got.zero !== want.zero) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"[%0t] mismatch: expected fl=%0d fr=%0d bl=%0d br=%0d z=%0d, ",
                      "got fl=%0d fr=%0d bl=%0d br=%0d z=%0d"},
                     $realtime, want.fl, want.fr, want.bl, want.br, want.zero,
                     got.fl, got.fr, got.bl, got.br, got.zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** mecanum_wheel_mixer_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    cmds_t none;
    none = '0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_DEADBAND;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_stick_forward <= '0;
    in_stick_sideways <= '0;
    in_throttle_axis <= '0;
    in_twist_axis <= '0;
    in_half_speed_button <= 1'b0;
    in_zero_encoders_button <= 1'b0;
    in_pivot_left_button <= 1'b0;
    in_pivot_right_button <= 1'b0;
    half_mode_q = 1'b0;
    last_half_q = 1'b0;
    deadband_q = DEADBAND_RESET;
    gain_q = RIGHT_GAIN_RESET;
    pivot_q = PIVOT_SPEED_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    //       fwd     side    thr     tw      hzlr     known fl      fr      bl      br
    add_row(0,      0,      0,      0,      4'b0000, 1,    0,      0,      0,      0);
    add_row(16384,  0,      0,      0,      4'b0000, 1,    -16384, 16062,  -16384, 16062);
    add_row(-16384, 0,      0,      0,      4'b0000, 1,    16384,  -16062, 16384,  -16062);
    add_row(1638,   0,      0,      0,      4'b0000, 1,    -1638,  1605,   -1638,  1605);
    add_row(1637,   0,      0,      0,      4'b0000, 1,    0,      0,      0,      0);
    add_row(-1637,  0,      0,      0,      4'b0000, 1,    0,      0,      0,      0);
    add_row(16384,  0,      0,      0,      4'b0010, 1,    0,      0,      -11469, -11243);
    add_row(0,      0,      0,      0,      4'b0001, 1,    0,      0,      11469,  11243);
    add_row(-16384, 5000,   0,      0,      4'b0111, 1,    0,      0,      -11469, -11243);
    add_row(0,      16384,  0,      0,      4'b0000, 0,    0,      0,      0,      0);
    add_row(0,      -32768, 0,      0,      4'b0000, 0,    0,      0,      0,      0);
    add_row(0,      0,      16384,  -16384, 4'b0000, 0,    0,      0,      0,      0);
    add_row(0,      0,      -32768, 32767,  4'b0000, 0,    0,      0,      0,      0);
    add_row(32767,  -32768, -32768, 32767,  4'b0100, 0,    0,      0,      0,      0);
    add_row(-32768, 32767,  32767,  -32768, 4'b0000, 0,    0,      0,      0,      0);
    add_row(8000,   -5000,  3000,   12000,  4'b0000, 0,    0,      0,      0,      0);
    add_row(-1,     -1,     -1,     -1,     4'b0100, 0,    0,      0,      0,      0);
    add_row(16384,  0,      0,      0,      4'b1000, 0,    0,      0,      0,      0);
    add_row(-3277,  3277,   1,      -3276,  4'b1000, 0,    0,      0,      0,      0);
    add_row(3277,   -3277,  1,      -1,     4'b0000, 0,    0,      0,      0,      0);
    add_row(-32768, -32768, -32768, -32768, 4'b1000, 0,    0,      0,      0,      0);
    add_row(-16383, 16383,  -16383, 16383,  4'b0000, 0,    0,      0,      0,      0);

    foreach (directed_plan[i])
      send_tick(directed_plan[i].tick, directed_plan[i].known, directed_plan[i].cmds);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: program_regs(15'd0, 16'd65535, 15'd16384);
          2: program_regs(15'd16384, 16'd0, 15'd0);
          3: program_regs(15'd1, 16'd32768, 15'd1);
          4: program_regs(LEVEL_W'($urandom_range(0, 16384)), GAIN_W'($urandom),
                          LEVEL_W'($urandom_range(0, 16384)));
          default: program_regs(DEADBAND_RESET, RIGHT_GAIN_RESET, PIVOT_SPEED_RESET);
        endcase
      end
      calm = (phase == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_tick(random_tick(), 1'b0, none);
    end
    calm = 1'b0;

    wait_idle();
    if (mismatch_cnt == 0 && expected_cmds.size() == 0)
      $display("** mecanum_wheel_mixer_core: PASSED **");
    else
      $display("** mecanum_wheel_mixer_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mwm_pkg.sv
rtl/mwm_front.sv
rtl/mwm_queue.sv
rtl/mwm_back.sv
rtl/mecanum_wheel_mixer_core.sv
tb/mecanum_wheel_mixer_core_test.sv
